// File: sv/radix_sort_descending_assert.svh
// Assertion macros for the descending radix sort block
`ifndef RADIX_SORT_DESCENDING_ASSERT_SVH
`define RADIX_SORT_DESCENDING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSD_ASSERT_IMPL(label, ante, cons)
`define RSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/rsd_pkg.sv
// Shared types and constants for the descending radix sort block
`timescale 1ns / 1ps
package rsd_pkg;
   localparam int KEY_W      = 64;
   localparam int TAG_W      = 16;
   localparam int DIGIT_W    = 8;
   localparam int HIST_DEPTH = 256;
   localparam int KB_W       = 4;
   localparam logic [KB_W-1:0] MAX_KEY_BYTES = 4'd8;
   localparam logic [KB_W-1:0] KB_RESET      = 4'd8;

   typedef enum logic [12:0] {
      ST_LOAD     = 13'b0000000000001,
      ST_CLEAR    = 13'b0000000000010,
      ST_CNT_RD   = 13'b0000000000100,
      ST_CNT_HIST = 13'b0000000001000,
      ST_CNT_WR   = 13'b0000000010000,
      ST_PFX_RD   = 13'b0000000100000,
      ST_PFX_WR   = 13'b0000001000000,
      ST_SCT_RD   = 13'b0000010000000,
      ST_SCT_HIST = 13'b0000100000000,
      ST_SCT_WR   = 13'b0001000000000,
      ST_OUT_RD   = 13'b0010000000000,
      ST_OUT_LD   = 13'b0100000000000,
      ST_OUT_WAIT = 13'b1000000000000
   } state_type;
endpackage

// File: sv/radix_sort_descending.sv
// Top level: record loader, radix pass sequencer and result emitter
// Load: one request per cycle. Sort: nb passes (clear, count, prefix, scatter
//   through one histogram port and one adder).
// Emit: each result is read, loaded and held until rsp_ready; the next set loads after.
// Reset (synchronous): set empty, overflow clear, key_bytes 8; no memory clear.
`timescale 1ns / 1ps
`include "radix_sort_descending_assert.svh"
module radix_sort_descending #(
   parameter int MAX_RECORDS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rsd_pkg::KEY_W-1:0]           req_key,
   input  logic [rsd_pkg::TAG_W-1:0]           req_tag,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rsd_pkg::KEY_W-1:0]           rsp_sorted_key,
   output logic [rsd_pkg::TAG_W-1:0]           rsp_sorted_tag,
   output logic                                rsp_final_res,
   output logic                                rsp_overflow,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsd_pkg::KB_W-1:0]            csr_key_bytes
);
   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

   rsd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in, idx_ff, idx_in, acc_ff, acc_in;
   logic                        drop_ff, drop_in, src_ff, src_in;
   logic [rsd_pkg::KB_W-1:0]    kb_ff, kb_in, nb_ff, nb_in, nb_sat;
   logic [2:0]                  pass_ff, pass_in;
   logic [rsd_pkg::DIGIT_W-1:0] dig_ff, dig_in, digit_ff, digit_in, cur_digit;
   logic                        rsp_valid_ff, rsp_valid_in, fin_ff, fin_in;
   logic [rsd_pkg::KEY_W-1:0]   rkey_ff, rkey_in;
   logic [rsd_pkg::TAG_W-1:0]   rtag_ff, rtag_in;

   logic                        st_wr_en, st_wr_bank;
   logic [AW-1:0]               st_wr_addr, st_rd_addr;
   logic [rsd_pkg::KEY_W-1:0]   st_wr_key, st_rd_key;
   logic [rsd_pkg::TAG_W-1:0]   st_wr_tag, st_rd_tag;
   logic                        h_wr_en;
   logic [rsd_pkg::DIGIT_W-1:0] h_wr_addr, h_rd_addr;
   logic [CW-1:0]               h_wr_data, h_rd_data, add_b, h_sum, cnt_next;
   logic                        req_acc, rsp_acc;

   rsd_store #(.DEPTH(MAX_RECORDS)) u_store (
      .clock(clock), .wr_en(st_wr_en), .wr_bank(st_wr_bank), .wr_addr(st_wr_addr),
      .wr_key(st_wr_key), .wr_tag(st_wr_tag), .rd_bank(src_ff), .rd_addr(st_rd_addr),
      .rd_key(st_rd_key), .rd_tag(st_rd_tag)
   );

   rsd_hist #(.CW(CW)) u_hist (
      .clock(clock), .wr_en(h_wr_en), .wr_addr(h_wr_addr), .wr_data(h_wr_data),
      .rd_addr(h_rd_addr), .rd_data(h_rd_data)
   );

   assign req_ready = (state_ff == rsd_pkg::ST_LOAD);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid_ff && rsp_ready;
   assign nb_sat    = (kb_ff > rsd_pkg::MAX_KEY_BYTES) ? rsd_pkg::MAX_KEY_BYTES : kb_ff;
   assign cnt_next  = (cnt_ff < MAX_CNT) ? cnt_ff + 1'b1 : cnt_ff;
   assign cur_digit = st_rd_key[{pass_ff, 3'b000} +: rsd_pkg::DIGIT_W];

   // shared histogram adder: increment, running sum or decrement
   always_comb begin
      case (state_ff)
         rsd_pkg::ST_CNT_WR: add_b = CW'(1);
         rsd_pkg::ST_PFX_WR: add_b = acc_ff;
         default:            add_b = '1;
      endcase
   end
   assign h_sum = h_rd_data + add_b;

   // store addressing: forward walk while counting, backward otherwise
   always_comb begin
      st_rd_addr = (state_ff == rsd_pkg::ST_CNT_RD || state_ff == rsd_pkg::ST_CNT_HIST ||
                    state_ff == rsd_pkg::ST_CNT_WR) ? idx_ff[AW-1:0]
                                                    : AW'(idx_ff - 1'b1);
      st_wr_en   = req_acc && (cnt_ff < MAX_CNT);
      st_wr_bank = 1'b0;
      st_wr_addr = cnt_ff[AW-1:0];
      st_wr_key  = req_key;
      st_wr_tag  = req_tag;
      if (state_ff == rsd_pkg::ST_SCT_WR) begin
         st_wr_en   = 1'b1;
         st_wr_bank = ~src_ff;
         st_wr_addr = h_sum[AW-1:0];
         st_wr_key  = st_rd_key;
         st_wr_tag  = st_rd_tag;
      end
   end

   // histogram port control
   always_comb begin
      h_rd_addr = dig_ff;
      if (state_ff == rsd_pkg::ST_CNT_HIST || state_ff == rsd_pkg::ST_SCT_HIST) begin
         h_rd_addr = cur_digit;
      end
      h_wr_en   = 1'b0;
      h_wr_addr = digit_ff;
      h_wr_data = h_sum;
      case (state_ff)
         rsd_pkg::ST_CLEAR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = dig_ff;
            h_wr_data = '0;
         end
         rsd_pkg::ST_CNT_WR, rsd_pkg::ST_SCT_WR: h_wr_en = 1'b1;
         rsd_pkg::ST_PFX_WR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = dig_ff;
         end
         default: h_wr_en = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      drop_in      = drop_ff;
      src_in       = src_ff;
      kb_in        = kb_ff;
      nb_in        = nb_ff;
      pass_in      = pass_ff;
      dig_in       = dig_ff;
      digit_in     = digit_ff;
      rsp_valid_in = rsp_valid_ff;
      fin_in       = fin_ff;
      rkey_in      = rkey_ff;
      rtag_in      = rtag_ff;
      if (csr_valid) begin
         kb_in = csr_key_bytes;
      end
      case (state_ff)
         rsd_pkg::ST_LOAD: begin
            if (req_acc) begin
               cnt_in  = cnt_next;
               drop_in = drop_ff || (cnt_ff == MAX_CNT);
               if (req_last) begin
                  nb_in   = nb_sat;
                  pass_in = 3'd0;
                  src_in  = 1'b0;
                  dig_in  = '0;
                  idx_in  = cnt_next;
                  if (cnt_next == '0) begin
                     state_in = rsd_pkg::ST_LOAD;
                  end else if (nb_sat == '0) begin
                     state_in = rsd_pkg::ST_OUT_RD;
                  end else begin
                     state_in = rsd_pkg::ST_CLEAR;
                  end
               end
            end
         end
         rsd_pkg::ST_CLEAR: begin
            dig_in = dig_ff + 1'b1;
            if (dig_ff == '1) begin
               idx_in   = '0;
               state_in = rsd_pkg::ST_CNT_RD;
            end
         end
         rsd_pkg::ST_CNT_RD:   state_in = rsd_pkg::ST_CNT_HIST;
         rsd_pkg::ST_CNT_HIST: begin
            digit_in = cur_digit;
            state_in = rsd_pkg::ST_CNT_WR;
         end
         rsd_pkg::ST_CNT_WR: begin
            idx_in   = idx_ff + 1'b1;
            state_in = rsd_pkg::ST_CNT_RD;
            if (idx_ff == cnt_ff - 1'b1) begin
               dig_in   = '0;
               acc_in   = '0;
               state_in = rsd_pkg::ST_PFX_RD;
            end
         end
         rsd_pkg::ST_PFX_RD:   state_in = rsd_pkg::ST_PFX_WR;
         rsd_pkg::ST_PFX_WR: begin
            acc_in   = h_sum;
            dig_in   = dig_ff + 1'b1;
            state_in = rsd_pkg::ST_PFX_RD;
            if (dig_ff == '1) begin
               idx_in   = cnt_ff;
               state_in = rsd_pkg::ST_SCT_RD;
            end
         end
         rsd_pkg::ST_SCT_RD:   state_in = rsd_pkg::ST_SCT_HIST;
         rsd_pkg::ST_SCT_HIST: begin
            digit_in = cur_digit;
            state_in = rsd_pkg::ST_SCT_WR;
         end
         rsd_pkg::ST_SCT_WR: begin
            idx_in   = idx_ff - 1'b1;
            state_in = rsd_pkg::ST_SCT_RD;
            if (idx_ff == CW'(1)) begin
               pass_in = pass_ff + 1'b1;
               src_in  = ~src_ff;
               dig_in  = '0;
               idx_in  = cnt_ff;
               if ({1'b0, pass_ff} == nb_ff - 1'b1) begin
                  state_in = rsd_pkg::ST_OUT_RD;
               end else begin
                  state_in = rsd_pkg::ST_CLEAR;
               end
            end
         end
         rsd_pkg::ST_OUT_RD:   state_in = rsd_pkg::ST_OUT_LD;
         rsd_pkg::ST_OUT_LD: begin
            rkey_in      = st_rd_key;
            rtag_in      = st_rd_tag;
            fin_in       = (idx_ff == CW'(1));
            rsp_valid_in = 1'b1;
            state_in     = rsd_pkg::ST_OUT_WAIT;
         end
         rsd_pkg::ST_OUT_WAIT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff - 1'b1;
               state_in     = rsd_pkg::ST_OUT_RD;
               if (fin_ff) begin
                  cnt_in   = '0;
                  drop_in  = 1'b0;
                  state_in = rsd_pkg::ST_LOAD;
               end
            end
         end
         default: state_in = rsd_pkg::ST_LOAD;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsd_pkg::ST_LOAD;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         kb_ff        <= rsd_pkg::KB_RESET;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         src_ff       <= 1'b0;
         nb_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         kb_ff        <= kb_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         src_ff       <= src_in;
         nb_ff        <= nb_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      dig_ff   <= dig_in;
      digit_ff <= digit_in;
      fin_ff   <= fin_in;
      rkey_ff  <= rkey_in;
      rtag_ff  <= rtag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rkey_ff;
   assign rsp_sorted_tag = rtag_ff;
   assign rsp_final_res  = fin_ff;
   assign rsp_overflow   = drop_ff;

   `RSD_ASSERT_IMPL(a_no_load_while_out, rsp_valid, !req_ready)
   `RSD_ASSERT_NEXT(a_final_reopens, rsp_valid && rsp_ready && rsp_final_res, req_ready)
   `RSD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= MAX_CNT)
endmodule

// File: sv/rsd_store.sv
// Ping-pong record stores, one write port and one registered read port
`timescale 1ns / 1ps
module rsd_store #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     wr_bank,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [rsd_pkg::KEY_W-1:0] wr_key,
   input  logic [rsd_pkg::TAG_W-1:0] wr_tag,
   input  logic                     rd_bank,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [rsd_pkg::KEY_W-1:0] rd_key,
   output logic [rsd_pkg::TAG_W-1:0] rd_tag
);
   logic [rsd_pkg::KEY_W-1:0] key_a [DEPTH];
   logic [rsd_pkg::TAG_W-1:0] tag_a [DEPTH];
   logic [rsd_pkg::KEY_W-1:0] key_b [DEPTH];
   logic [rsd_pkg::TAG_W-1:0] tag_b [DEPTH];
   logic [rsd_pkg::KEY_W-1:0] key_a_ff, key_b_ff;
   logic [rsd_pkg::TAG_W-1:0] tag_a_ff, tag_b_ff;
   logic                      bank_ff;

   // write the selected bank
   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         key_a[wr_addr] <= wr_key;
         tag_a[wr_addr] <= wr_tag;
      end
      if (wr_en && wr_bank) begin
         key_b[wr_addr] <= wr_key;
         tag_b[wr_addr] <= wr_tag;
      end
   end

   // read both banks, pick one after the register
   always_ff @(posedge clock) begin
      key_a_ff <= key_a[rd_addr];
      tag_a_ff <= tag_a[rd_addr];
      key_b_ff <= key_b[rd_addr];
      tag_b_ff <= tag_b[rd_addr];
      bank_ff  <= rd_bank;
   end

   assign rd_key = bank_ff ? key_b_ff : key_a_ff;
   assign rd_tag = bank_ff ? tag_b_ff : tag_a_ff;
endmodule

// File: sv/rsd_hist.sv
// Digit histogram memory with registered read
`timescale 1ns / 1ps
module rsd_hist #(
   parameter int CW = 7
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [rsd_pkg::DIGIT_W-1:0]   wr_addr,
   input  logic [CW-1:0]                 wr_data,
   input  logic [rsd_pkg::DIGIT_W-1:0]   rd_addr,
   output logic [CW-1:0]                 rd_data
);
   logic [CW-1:0] mem [rsd_pkg::HIST_DEPTH];
   logic [CW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
